[design/sfdcd_pkg.sv]
// Shared types and constants of the sensor frame deframer and change detector.
package sfdcd_pkg;

    // Register indexes on the configuration write channel.
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_IN_MIN      = 3'd0;
    localparam t_cfg_idx CFG_IN_MAX      = 3'd1;
    localparam t_cfg_idx CFG_OUT_MAX     = 3'd2;
    localparam t_cfg_idx CFG_CHANGE_LOW  = 3'd3;
    localparam t_cfg_idx CFG_CHANGE_HIGH = 3'd4;

    // Register values after reset.
    localparam logic [15:0] RST_IN_MIN      = 16'd30;
    localparam logic [15:0] RST_IN_MAX      = 16'd4000;
    localparam logic [10:0] RST_OUT_MAX     = 11'd1024;
    localparam logic [10:0] RST_CHANGE_LOW  = 11'd300;
    localparam logic [10:0] RST_CHANGE_HIGH = 11'd2000;

    // Sync marker bytes and frame bookkeeping.
    localparam logic [7:0] MARK_ZERO = 8'h00;
    localparam logic [7:0] MARK_LAST = 8'h01;
    localparam logic [2:0] READY_FRAMES = 3'd7;

    // Scaling arithmetic widths.
    localparam int RAW_W   = 16;
    localparam int SCALE_W = 11;
    localparam int PROD_W  = RAW_W + SCALE_W;

    typedef logic [SCALE_W-1:0] t_scaled;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_CMP  = 5'b01000,
        S_PUSH = 5'b10000
    } t_state;

endpackage

[design/sfdcd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sfdcd_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/sensor_frame_deframer_change_detect_core.sv]
// Top level: byte deframer, channel scaling and change detection against older frames.
//
// Bytes arrive one per request and shift through a window of 2*CHANNELS+4 bytes. A byte
// that does not close a frame is taken without stalling the input. The first 00 00 00 01
// marker only synchronizes; each later marker with at least 2*CHANNELS bytes before it
// closes a frame. Then one shared multiply and restoring-divide unit scales the channels
// one after another: per channel a multiply step, eleven divide steps (skipped when the
// raw value lies at or outside the input range) and a compare step against the value
// stored COMPARE_LAG frames earlier; after the last channel a push step waits while the
// result register is held by the output stall. The input is stalled meanwhile.
// The scaled history sits in a RAM of CHANNELS*COMPARE_LAG words of 11 bits.
module sensor_frame_deframer_change_detect_core #(
    parameter int CHANNELS    = 4,
    parameter int COMPARE_LAG = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // byte input channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [7:0]             i_rx_byte,
    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [10:0]            o_chan_a,
    output logic [10:0]            o_chan_b,
    output logic [10:0]            o_chan_c,
    output logic [10:0]            o_chan_d,
    output logic [3:0]             o_change_mask,
    output logic                   o_change_any,
    output logic                   o_history_ready,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  sfdcd_pkg::t_cfg_idx    i_cfg_index,
    input  logic [15:0]            i_cfg_data
);

    import sfdcd_pkg::*;

    localparam int WIN   = 2 * CHANNELS + 4;
    localparam int CNT_W = $clog2(WIN + 1);
    localparam int KW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HW    = (COMPARE_LAG > 1) ? $clog2(COMPARE_LAG) : 1;
    localparam int DEPTH = CHANNELS * COMPARE_LAG;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LANES = (CHANNELS < 4) ? CHANNELS : 4;

    // Configuration registers.
    logic [15:0] r_in_min;
    logic [15:0] r_in_max;
    t_scaled     r_out_max;
    t_scaled     r_change_low;
    t_scaled     r_change_high;

    // Deframer state.
    logic [7:0]       r_win [0:WIN-1];
    logic [7:0]       n_win [0:WIN-1];
    logic             r_synced;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [HW-1:0]    r_hptr;
    logic [2:0]       r_frames;

    // Sequencer and shared arithmetic unit.
    t_state           r_state;
    logic [KW-1:0]    r_k;
    logic [3:0]       r_step;
    logic [15:0]      r_span;
    logic [PROD_W-1:0] r_num;
    t_scaled          r_scaled;
    logic             r_ready;
    logic [AW-1:0]    r_addr;

    // Frame result being built.
    t_scaled          r_res [0:3];
    logic [3:0]       r_mask;
    logic             r_any;

    // Output register.
    logic             r_out_valid;
    t_scaled          r_out_chan [0:3];
    logic [3:0]       r_out_mask;
    logic             r_out_any;
    logic             r_out_ready;

    logic [RAW_W-1:0] w_raw_lane [0:CHANNELS-1];
    logic [RAW_W-1:0] w_raw;
    logic             w_in_acc;
    logic             w_marker;
    logic             w_zero;
    logic             w_top;
    logic [16:0]      w_trial;
    logic             w_qbit;
    t_scaled          w_quo;
    t_scaled          w_old;
    t_scaled          w_diff;
    logic             w_flag;
    logic             w_out_free;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Window after shifting in the offered byte.
    always_comb begin
        for (int i = 0; i < WIN - 1; i++) begin
            n_win[i] = r_win[i+1];
        end
        n_win[WIN-1] = i_rx_byte;
    end

    assign n_count  = (r_count < CNT_W'(WIN)) ? r_count + CNT_W'(1) : r_count;
    assign w_marker = (n_win[WIN-4] == MARK_ZERO) && (n_win[WIN-3] == MARK_ZERO) &&
                      (n_win[WIN-2] == MARK_ZERO) && (n_win[WIN-1] == MARK_LAST);

    // Raw channel values sit at fixed window positions, little endian.
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            w_raw_lane[c] = {r_win[2*c+1], r_win[2*c]};
        end
    end
    assign w_raw = w_raw_lane[r_k];

    assign w_zero = (r_in_max <= r_in_min) || (w_raw <= r_in_min);
    assign w_top  = (w_raw >= r_in_max);

    // One restoring divide step on {remainder, low dividend bits}.
    assign w_trial = {r_num[PROD_W-1:SCALE_W], r_num[SCALE_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_span});
    assign w_quo   = {r_num[SCALE_W-2:0], w_qbit};

    assign w_diff = (r_scaled > w_old) ? r_scaled - w_old : w_old - r_scaled;
    assign w_flag = r_ready && (w_diff > r_change_low) && (w_diff < r_change_high);

    sfdcd_ram #(
        .WIDTH(SCALE_W),
        .DEPTH(DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (r_state == S_CMP),
        .i_waddr (r_addr),
        .i_wdata (r_scaled),
        .i_re    (r_state == S_MUL),
        .i_raddr (r_addr),
        .o_rdata (w_old)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_min      <= RST_IN_MIN;
            r_in_max      <= RST_IN_MAX;
            r_out_max     <= RST_OUT_MAX;
            r_change_low  <= RST_CHANGE_LOW;
            r_change_high <= RST_CHANGE_HIGH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IN_MIN:      r_in_min      <= i_cfg_data;
                CFG_IN_MAX:      r_in_max      <= i_cfg_data;
                CFG_OUT_MAX:     r_out_max     <= i_cfg_data[SCALE_W-1:0];
                CFG_CHANGE_LOW:  r_change_low  <= i_cfg_data[SCALE_W-1:0];
                CFG_CHANGE_HIGH: r_change_high <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Deframer, sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN; i++) begin
                r_win[i] <= '0;
            end
            r_synced    <= 1'b0;
            r_count     <= '0;
            r_hptr      <= '0;
            r_frames    <= '0;
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A push in the same cycle refills the register instead.
            if (r_out_valid && !i_out_stall && (r_state != S_PUSH)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_win   <= n_win;
                        if (w_marker) begin
                            r_synced <= 1'b1;
                            r_count  <= '0;
                            // A synced marker after a full frame of bytes closes a frame.
                            if (r_synced && n_count >= CNT_W'(WIN)) begin
                                if (r_frames < READY_FRAMES) begin
                                    r_frames <= r_frames + 3'd1;
                                end
                                r_ready <= (r_frames >= READY_FRAMES - 3'd1);
                                r_k     <= '0;
                                r_addr  <= AW'(r_hptr) * AW'(CHANNELS);
                                r_mask  <= '0;
                                r_any   <= 1'b0;
                                for (int l = 0; l < 4; l++) begin
                                    r_res[l] <= '0;
                                end
                                r_state <= S_MUL;
                            end
                        end else begin
                            r_count <= n_count;
                        end
                    end
                end
                S_MUL: begin
                    r_span <= r_in_max - r_in_min;
                    r_num  <= PROD_W'(w_raw - r_in_min) * PROD_W'(r_out_max);
                    r_step <= '0;
                    if (w_zero) begin
                        r_scaled <= '0;
                        r_state  <= S_CMP;
                    end else if (w_top) begin
                        r_scaled <= r_out_max;
                        r_state  <= S_CMP;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_num[PROD_W-1:SCALE_W] <= w_qbit ? w_trial[15:0] - r_span : w_trial[15:0];
                    r_num[SCALE_W-1:0]      <= w_quo;
                    r_step                  <= r_step + 4'd1;
                    if (r_step == 4'(SCALE_W - 1)) begin
                        r_scaled <= w_quo;
                        r_state  <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (w_flag) begin
                        r_any <= 1'b1;
                    end
                    for (int l = 0; l < LANES; l++) begin
                        if (int'(r_k) == l) begin
                            r_res[l]  <= r_scaled;
                            r_mask[l] <= w_flag;
                        end
                    end
                    if (r_k == KW'(CHANNELS - 1)) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_k     <= r_k + KW'(1);
                        r_addr  <= r_addr + AW'(1);
                        r_state <= S_MUL;
                    end
                end
                S_PUSH: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        for (int l = 0; l < 4; l++) begin
                            r_out_chan[l] <= r_res[l];
                        end
                        r_out_mask  <= r_mask;
                        r_out_any   <= r_any;
                        r_out_ready <= r_ready;
                        r_hptr      <= (r_hptr == HW'(COMPARE_LAG - 1)) ? '0 : r_hptr + HW'(1);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_chan_a        = r_out_chan[0];
    assign o_chan_b        = r_out_chan[1];
    assign o_chan_c        = r_out_chan[2];
    assign o_chan_d        = r_out_chan[3];
    assign o_change_mask   = r_out_mask;
    assign o_change_any    = r_out_any;
    assign o_history_ready = r_out_ready;

endmodule
